// ----- src/srdb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srdb_pkg
// shared types, constants and helpers of the sequence reorder / dedup buffer
// ----------------------------------------------------------------------------
package srdb_pkg;

   localparam int SEQ_W      = 7;
   localparam int TAG_W      = 16;
   localparam int STAT_W     = 3;
   localparam int PEND_DEPTH = 32;
   localparam int HIST_DEPTH = 17;

   localparam logic [SEQ_W:0]   SEQ_MODULUS     = 8'd100;
   localparam logic [SEQ_W-1:0] START_SEQ_RESET = 7'd99;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_STORED = 3'd0;
   localparam logic [STAT_W-1:0] STAT_DUP    = 3'd1;
   localparam logic [STAT_W-1:0] STAT_OLD    = 3'd2;
   localparam logic [STAT_W-1:0] STAT_BAD    = 3'd3;
   localparam logic [STAT_W-1:0] STAT_FULL   = 3'd4;
   localparam logic [STAT_W-1:0] STAT_DELIV  = 3'd5;
   localparam logic [STAT_W-1:0] STAT_NONE   = 3'd6;

   // request kinds
   localparam logic REQ_ARRIVAL = 1'b0;
   localparam logic REQ_DRAIN   = 1'b1;

   typedef struct packed {
      logic             req_type;
      logic [SEQ_W-1:0] seq;
      logic [TAG_W-1:0] payload_tag;
   } req_beat_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [SEQ_W-1:0]  delivered_seq;
      logic [TAG_W-1:0]  delivered_tag;
      logic              last;
   } rsp_beat_type;

   // broadcast to every pending cell
   typedef struct packed {
      logic [SEQ_W-1:0] query;
      logic [TAG_W-1:0] wr_tag;
      logic             store;
      logic             deliver;
   } pend_cmd_type;

   // broadcast to every history cell
   typedef struct packed {
      logic [SEQ_W-1:0] query;
      logic             push;
   } hist_cmd_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_DECIDE
   } state_type;

   // successor of a sequence number, wrapping at the modulus
   function automatic logic [SEQ_W-1:0] next_seq(input logic [SEQ_W-1:0] cur);
      logic [SEQ_W:0] sum;
      sum = {1'b0, cur} + {{SEQ_W{1'b0}}, 1'b1};
      return (sum >= SEQ_MODULUS) ? '0 : sum[SEQ_W-1:0];
   endfunction

endpackage : srdb_pkg
`default_nettype wire

// ----- src/srdb_pend_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srdb_pend_cell
// one pending slot: holds a packet number and tag, matches the broadcast
// query, and takes part in the lowest-free-slot and tag-collect chains
// ----------------------------------------------------------------------------
module srdb_pend_cell (
   input  wire                         clock,
   input  wire                         reset,
   input  srdb_pkg::pend_cmd_type      cmd,
   input  wire                         free_below_i,
   output logic                        free_below_o,
   input  wire  [srdb_pkg::TAG_W-1:0]  tag_chain_i,
   output logic [srdb_pkg::TAG_W-1:0]  tag_chain_o,
   output logic                        hit_o,
   output logic                        pick_o
);
   import srdb_pkg::*;

   logic             valid_ff, valid_in;
   logic [SEQ_W-1:0] seq_ff;
   logic [TAG_W-1:0] tag_ff;
   logic             hit_ff, pick_ff;

   // free slot ripple: this cell is the lowest free one when nothing below is
   assign free_below_o = free_below_i | ~valid_ff;
   assign tag_chain_o  = tag_chain_i | (hit_ff ? tag_ff : '0);
   assign hit_o        = hit_ff;
   assign pick_o       = pick_ff;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.store && pick_ff) begin
         valid_in = 1'b1;
      end else if (cmd.deliver && hit_ff) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
         pick_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= valid_ff && (seq_ff == cmd.query) && !(cmd.deliver && hit_ff);
         pick_ff  <= ~valid_ff & ~free_below_i;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store && pick_ff) begin
         seq_ff <= cmd.query;
         tag_ff <= cmd.wr_tag;
      end
   end

endmodule : srdb_pend_cell
`default_nettype wire

// ----- src/srdb_hist_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srdb_hist_cell
// one stage of the delivered-number history shift line
// ----------------------------------------------------------------------------
module srdb_hist_cell (
   input  wire                         clock,
   input  wire                         reset,
   input  srdb_pkg::hist_cmd_type      cmd,
   input  wire                         valid_i,
   input  wire  [srdb_pkg::SEQ_W-1:0]  seq_i,
   output logic                        valid_o,
   output logic [srdb_pkg::SEQ_W-1:0]  seq_o,
   output logic                        hit_o
);
   import srdb_pkg::*;

   logic             valid_ff;
   logic [SEQ_W-1:0] seq_ff;
   logic             hit_ff;

   assign valid_o = valid_ff;
   assign seq_o   = seq_ff;
   assign hit_o   = hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         if (cmd.push) begin
            valid_ff <= valid_i;
         end
         hit_ff <= valid_ff && (seq_ff == cmd.query);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         seq_ff <= seq_i;
      end
   end

endmodule : srdb_hist_cell
`default_nettype wire

// ----- src/sequence_reorder_dedup_buffer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sequence_reorder_dedup_buffer
// receive-side reorder buffer for packets numbered modulo 100, with
// duplicate and replay suppression
// ----------------------------------------------------------------------------
// usage:
//  - req channel (valid/ready): one beat is either a packet arrival (number
//    and payload tag) or a drain request
//  - rsp channel (valid/ready): an arrival yields one beat with its status;
//    a drain yields one delivered beat per in-order packet, or a single
//    none-ready beat; the final beat of a request carries last
//  - csr_we/csr_wdata load the number taken as last delivered; write only
//    while the block is idle
//  - timing: an arrival passes the lookup and decide states from accept to
//    its beat in the output register; a drain passes one lookup/decide pair
//    per delivered packet and one more for its final beat. the pair works
//    around the row of slot cells: lookup registers the match of every cell,
//    decide acts on it
//  - one request is in work at a time; req_ready is high only when idle, so
//    the next request is taken in the idle state after the final beat loads
//  - a result waiting on a stalled receiver sits in the output register and
//    a drain keeps one delivered packet in a hold stage, so a delivery step
//    only waits when both are full; an arrival or the final beat of a drain
//    waits on the output register alone
//  - reset (synchronous) empties all pending slots and the history and sets
//    the last delivered number to 99; no clearing pass is needed
// ----------------------------------------------------------------------------
module sequence_reorder_dedup_buffer (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  srdb_pkg::req_beat_type      req_data,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output srdb_pkg::rsp_beat_type      rsp_data,
   input  wire                         csr_we,
   input  wire  [srdb_pkg::SEQ_W-1:0]  csr_wdata
);
   import srdb_pkg::*;

   // control and request registers
   state_type        state_ff, state_in;
   logic [SEQ_W-1:0] query_ff, query_in;
   logic             rtype_ff, rtype_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic [SEQ_W-1:0] last_seq_ff, last_seq_in;

   // hold stage: last delivered packet, waiting to learn if it is the final one
   logic             hold_valid_ff, hold_valid_in;
   logic [SEQ_W-1:0] hold_seq_ff, hold_seq_in;
   logic [TAG_W-1:0] hold_tag_ff, hold_tag_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_beat_type     rsp_data_ff, rsp_data_in;

   logic             out_load, out_free;
   pend_cmd_type     pcmd;
   hist_cmd_type     hcmd;

   // pending cell row
   logic [PEND_DEPTH:0]  free_chain;
   logic [TAG_W-1:0]     tag_chain [PEND_DEPTH+1];
   logic [PEND_DEPTH-1:0] pend_hit, pend_pick;

   // history shift line
   logic [HIST_DEPTH:0]  hvalid_chain;
   logic [SEQ_W-1:0]     hseq_chain [HIST_DEPTH+1];
   logic [HIST_DEPTH-1:0] hist_hit;

   logic any_pend_hit, any_hist_hit, is_full;

   assign free_chain[0]   = 1'b0;
   assign tag_chain[0]    = '0;
   assign hvalid_chain[0] = 1'b1;           // newest number enters at stage 0
   assign hseq_chain[0]   = query_ff;

   for (genvar i = 0; i < PEND_DEPTH; i++) begin : g_pend
      srdb_pend_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (pcmd),
         .free_below_i (free_chain[i]),
         .free_below_o (free_chain[i+1]),
         .tag_chain_i  (tag_chain[i]),
         .tag_chain_o  (tag_chain[i+1]),
         .hit_o        (pend_hit[i]),
         .pick_o       (pend_pick[i])
      );
   end

   for (genvar j = 0; j < HIST_DEPTH; j++) begin : g_hist
      srdb_hist_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .cmd     (hcmd),
         .valid_i (hvalid_chain[j]),
         .seq_i   (hseq_chain[j]),
         .valid_o (hvalid_chain[j+1]),
         .seq_o   (hseq_chain[j+1]),
         .hit_o   (hist_hit[j])
      );
   end

   assign any_pend_hit = |pend_hit;
   assign any_hist_hit = |hist_hit;
   // no cell picked as lowest free slot means every slot is taken
   assign is_full      = ~|pend_pick;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         last_seq_ff   <= START_SEQ_RESET;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_seq_ff   <= last_seq_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff    <= query_in;
      rtype_ff    <= rtype_in;
      tag_ff      <= tag_in;
      hold_seq_ff <= hold_seq_in;
      hold_tag_ff <= hold_tag_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      query_in      = query_ff;
      rtype_in      = rtype_ff;
      tag_in        = tag_ff;
      last_seq_in   = csr_we ? csr_wdata : last_seq_ff;
      hold_valid_in = hold_valid_ff;
      hold_seq_in   = hold_seq_ff;
      hold_tag_in   = hold_tag_ff;
      rsp_data_in   = rsp_data_ff;
      out_load      = 1'b0;
      req_ready     = 1'b0;
      pcmd          = '{query: query_ff, wr_tag: tag_ff, store: 1'b0, deliver: 1'b0};
      hcmd          = '{query: query_ff, push: 1'b0};

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               rtype_in = req_data.req_type;
               tag_in   = req_data.payload_tag;
               // a drain looks for the successor of the last delivered number
               query_in = (req_data.req_type == REQ_DRAIN) ? next_seq(last_seq_ff)
                                                           : req_data.seq;
               state_in = S_LOOKUP;
            end
         end

         S_LOOKUP: begin
            // cells register their match against query this cycle
            state_in = S_DECIDE;
         end

         S_DECIDE: begin
            if (rtype_ff == REQ_ARRIVAL) begin
               if (out_free) begin
                  out_load    = 1'b1;
                  rsp_data_in = '{status: STAT_STORED, delivered_seq: '0,
                                  delivered_tag: '0, last: 1'b1};
                  if ({1'b0, query_ff} >= SEQ_MODULUS) begin
                     rsp_data_in.status = STAT_BAD;
                  end else if (any_pend_hit) begin
                     rsp_data_in.status = STAT_DUP;
                  end else if (any_hist_hit) begin
                     rsp_data_in.status = STAT_OLD;
                  end else if (is_full) begin
                     rsp_data_in.status = STAT_FULL;
                  end else begin
                     pcmd.store = 1'b1;
                  end
                  state_in = S_IDLE;
               end
            end else if (any_pend_hit) begin
               // successor found: release the held one (not final), hold this one
               if (!hold_valid_ff || out_free) begin
                  if (hold_valid_ff) begin
                     out_load    = 1'b1;
                     rsp_data_in = '{status: STAT_DELIV, delivered_seq: hold_seq_ff,
                                     delivered_tag: hold_tag_ff, last: 1'b0};
                  end
                  hold_valid_in = 1'b1;
                  hold_seq_in   = query_ff;
                  hold_tag_in   = tag_chain[PEND_DEPTH];
                  pcmd.deliver  = 1'b1;
                  hcmd.push     = 1'b1;
                  last_seq_in   = query_ff;
                  query_in      = next_seq(query_ff);
                  state_in      = S_LOOKUP;
               end
            end else if (out_free) begin
               // no successor: the held packet is the final beat, else none ready
               out_load = 1'b1;
               if (hold_valid_ff) begin
                  rsp_data_in = '{status: STAT_DELIV, delivered_seq: hold_seq_ff,
                                  delivered_tag: hold_tag_ff, last: 1'b1};
               end else begin
                  rsp_data_in = '{status: STAT_NONE, delivered_seq: '0,
                                  delivered_tag: '0, last: 1'b1};
               end
               hold_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // pending numbers are unique, so at most one slot matches
   a_pend_hit_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(pend_hit))
      else $error("more than one pending slot matched");

   // the free-slot ripple selects at most one cell
   a_pick_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(pend_pick))
      else $error("more than one free slot picked");

   // a delivered beat always carries an in-range number
   a_deliv_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == STAT_DELIV)
         |-> ({1'b0, rsp_data_ff.delivered_seq} < SEQ_MODULUS))
      else $error("delivered number out of range");

   // the hold stage is empty whenever the block is idle
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !hold_valid_ff)
      else $error("held packet left behind after a drain");

   // a store only goes into a buffer with a free slot and no matching pending number
   a_store_one: assert property (@(posedge clock) disable iff (reset)
      pcmd.store |-> !is_full && !any_pend_hit)
      else $error("store into a full buffer or over a pending number");

endmodule : sequence_reorder_dedup_buffer
`default_nettype wire
